### sv/arpc_pkg.sv
// Shared types and constants for the ARP cache and responder.
package arpc_pkg;

   localparam int IP_W  = 32;
   localparam int MAC_W = 48;
   localparam int OP_W  = 16;

   // request kinds
   localparam logic [1:0] REQ_PACKET = 2'd0;
   localparam logic [1:0] REQ_INSERT = 2'd1;
   localparam logic [1:0] REQ_SEARCH = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_STORED  = 2'd0;
   localparam logic [1:0] KIND_REPLIED = 2'd1;
   localparam logic [1:0] KIND_HIT     = 2'd2;
   localparam logic [1:0] KIND_MISS    = 2'd3;

   localparam logic [OP_W-1:0] ARP_OP_REQUEST = 16'd1;

   // register indexes
   localparam logic CSR_OWN_IP  = 1'b0;
   localparam logic CSR_OWN_MAC = 1'b1;

   localparam logic [IP_W-1:0]  OWN_IP_RESET  = 32'h0A02_000F;
   localparam logic [MAC_W-1:0] OWN_MAC_RESET = '0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_HOLD
   } arpc_state_type;

   typedef struct packed {
      logic [1:0]       req_type;
      logic [OP_W-1:0]  op_code;
      logic [IP_W-1:0]  peer_ip;
      logic [MAC_W-1:0] peer_mac;
      logic [IP_W-1:0]  target_ip;
   } arpc_item_type;

   typedef struct packed {
      logic [1:0]       result_kind;
      logic [MAC_W-1:0] out_mac;
      logic [IP_W-1:0]  out_ip;
   } arpc_res_type;

   // store request into the ring
   typedef struct packed {
      logic             en;
      logic [IP_W-1:0]  ip;
      logic [MAC_W-1:0] mac;
   } arpc_wr_type;

   // registered read stage of the table
   typedef struct packed {
      logic             stage;  // read data present this cycle
      logic             live;   // entry holds a valid pair
      logic             last;   // entry is the final slot of the ring
      logic [IP_W-1:0]  ip;
      logic [MAC_W-1:0] mac;
   } arpc_rd_type;

endpackage

### sv/arp_cache_and_responder_core.sv
// Top level of the ARP cache and responder: ports, registers, output stage.
//
// ARP cache with request responder. Each request word is one of: a received
// ARP packet (sender pair stored in the next ring slot; a request for own_ip
// also yields a reply result addressed to the sender), a direct insert of an
// IP/MAC pair, or a search by IP that returns the MAC of the lowest valid
// matching slot or a miss. Request kind 3 is dropped with no result. The
// ring holds TABLE_DEPTH pairs in a single-port RAM; after reset slot 0 holds
// the broadcast pair and the ring pointer sits at 1. Validity comes from the
// ring pointer and a wrap flag, so there is no clearing pass and the block
// is ready right out of reset. One word is worked at a time and req_tready
// is low while it runs. Packet and insert words write the ring in the
// execute state and offer their result from the hold state. A search reads
// one slot per cycle through a single comparator, from slot 0 upward behind
// the registered RAM read port, and ends at the first hit or the last slot.
// A finished result sits in an output register, so a stalled rsp side holds
// at most one result there plus one in the sequencer. own_mac is only held
// in a register, drives no port and appears in no result word.
module arp_cache_and_responder_core #(
   parameter int TABLE_DEPTH = 512
) (
   input  logic         clock,
   input  logic         reset,
   // req_tdata: req_type[1:0], op_code[17:2], peer_ip[49:18],
   //            peer_mac[97:50], target_ip[129:98], zero pad[135:130]
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [135:0] req_tdata,
   // rsp_tdata: result_kind[1:0], out_mac[49:2], out_ip[81:50], zero pad[87:82]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [87:0]  rsp_tdata,
   // csr_index: 0 own_ip, 1 own_mac
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [47:0]  csr_wdata
);
   import arpc_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   logic [IP_W-1:0]  own_ip_ff, own_ip_in;
   logic [MAC_W-1:0] own_mac_ff, own_mac_in;

   arpc_item_type    item;
   arpc_wr_type      wr;
   arpc_rd_type      rd;
   arpc_res_type     res;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             res_valid;
   logic             res_ready;

   logic             rsp_valid_ff, rsp_valid_in;
   arpc_res_type     rsp_data_ff, rsp_data_in;

   // unpack the request word
   assign item.req_type  = req_tdata[1:0];
   assign item.op_code   = req_tdata[17:2];
   assign item.peer_ip   = req_tdata[49:18];
   assign item.peer_mac  = req_tdata[97:50];
   assign item.target_ip = req_tdata[129:98];

   // config writes
   always_comb begin
      own_ip_in  = own_ip_ff;
      own_mac_in = own_mac_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_OWN_IP:  own_ip_in  = csr_wdata[IP_W-1:0];
            CSR_OWN_MAC: own_mac_in = csr_wdata;
            default:     own_ip_in  = own_ip_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ip_ff  <= OWN_IP_RESET;
         own_mac_ff <= OWN_MAC_RESET;
      end else begin
         own_ip_ff  <= own_ip_in;
         own_mac_ff <= own_mac_in;
      end
   end

   arpc_ctrl #(
      .DEPTH (TABLE_DEPTH),
      .IDX_W (IDX_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .item      (item),
      .own_ip    (own_ip_ff),
      .wr        (wr),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd        (rd),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   arpc_table #(
      .DEPTH (TABLE_DEPTH),
      .IDX_W (IDX_W)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd      (rd)
   );

   // output register: loads when empty or being drained this cycle
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_data_ff.out_ip, rsp_data_ff.out_mac,
                        rsp_data_ff.result_kind};

endmodule

### sv/arpc_table.sv
// Ring store of IP/MAC pairs with fill pointer based validity.
module arpc_table #(
   parameter int DEPTH = 512,
   parameter int IDX_W = 9
) (
   input  logic                 clock,
   input  logic                 reset,
   input  arpc_pkg::arpc_wr_type wr,
   input  logic                 rd_en,
   input  logic [IDX_W-1:0]     rd_addr,
   output arpc_pkg::arpc_rd_type rd
);
   import arpc_pkg::*;

   localparam int ENT_W = IP_W + MAC_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

   logic [ENT_W-1:0] mem_ff [DEPTH];
   logic [ENT_W-1:0] rd_data_ff;

   logic [IDX_W-1:0] slot_ff, slot_in;
   logic             wrapped_ff, wrapped_in;
   logic             slot0_set_ff, slot0_set_in;
   logic             stage_ff, stage_in;
   logic             live_ff, live_in;
   logic             last_ff, last_in;
   logic             bcast_ff, bcast_in;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[slot_ff] <= {wr.ip, wr.mac};
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_comb begin
      slot_in      = slot_ff;
      wrapped_in   = wrapped_ff;
      slot0_set_in = slot0_set_ff;
      if (wr.en) begin
         if (slot_ff == '0) begin
            slot0_set_in = 1'b1;
         end
         if (slot_ff == LAST_IDX) begin
            slot_in    = '0;
            wrapped_in = 1'b1;
         end else begin
            slot_in = slot_ff + IDX_W'(1);
         end
      end
      // every slot below the pointer holds a pair (slot 0 the broadcast pair until written); after a wrap all do
      stage_in = rd_en;
      live_in  = wrapped_ff || (rd_addr < slot_ff);
      last_in  = (rd_addr == LAST_IDX);
      bcast_in = (rd_addr == '0) && !slot0_set_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= IDX_W'(1);
         wrapped_ff   <= 1'b0;
         slot0_set_ff <= 1'b0;
         stage_ff     <= 1'b0;
      end else begin
         slot_ff      <= slot_in;
         wrapped_ff   <= wrapped_in;
         slot0_set_ff <= slot0_set_in;
         stage_ff     <= stage_in;
      end
   end

   always_ff @(posedge clock) begin
      live_ff  <= live_in;
      last_ff  <= last_in;
      bcast_ff <= bcast_in;
   end

   // slot 0 reads as the broadcast pair until first overwritten
   assign rd.stage = stage_ff;
   assign rd.live  = live_ff;
   assign rd.last  = last_ff;
   assign rd.ip    = bcast_ff ? '1 : rd_data_ff[ENT_W-1:MAC_W];
   assign rd.mac   = bcast_ff ? '1 : rd_data_ff[MAC_W-1:0];

endmodule

### sv/arpc_ctrl.sv
// Sequencer: store path, reply decision and the one-entry-per-cycle search.
module arpc_ctrl #(
   parameter int DEPTH = 512,
   parameter int IDX_W = 9
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  arpc_pkg::arpc_item_type       item,
   input  logic [arpc_pkg::IP_W-1:0]     own_ip,
   output arpc_pkg::arpc_wr_type         wr,
   output logic                          rd_en,
   output logic [IDX_W-1:0]              rd_addr,
   input  arpc_pkg::arpc_rd_type         rd,
   output logic                          res_valid,
   input  logic                          res_ready,
   output arpc_pkg::arpc_res_type        res
);
   import arpc_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

   arpc_state_type   state_ff, state_in;
   arpc_item_type    item_ff, item_in;
   arpc_res_type     res_ff, res_in;
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic             issue_done_ff, issue_done_in;
   logic             hit;

   // the shared key compare
   assign hit = rd.live && (rd.ip == item_ff.peer_ip);

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      res_in        = res_ff;
      addr_in       = addr_ff;
      issue_done_in = issue_done_ff;
      req_ready     = 1'b0;
      res_valid     = 1'b0;
      rd_en         = 1'b0;
      wr            = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               item_in  = item;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_in = '0;
            case (item_ff.req_type)
               REQ_PACKET: begin
                  wr.en  = 1'b1;
                  wr.ip  = item_ff.peer_ip;
                  wr.mac = item_ff.peer_mac;
                  if (item_ff.op_code == ARP_OP_REQUEST &&
                      item_ff.target_ip == own_ip) begin
                     res_in.result_kind = KIND_REPLIED;
                     res_in.out_mac     = item_ff.peer_mac;
                     res_in.out_ip      = item_ff.peer_ip;
                  end else begin
                     res_in.result_kind = KIND_STORED;
                  end
                  state_in = ST_HOLD;
               end
               REQ_INSERT: begin
                  wr.en              = 1'b1;
                  wr.ip              = item_ff.peer_ip;
                  wr.mac             = item_ff.peer_mac;
                  res_in.result_kind = KIND_STORED;
                  state_in           = ST_HOLD;
               end
               REQ_SEARCH: begin
                  addr_in       = '0;
                  issue_done_in = 1'b0;
                  state_in      = ST_SCAN;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_SCAN: begin
            rd_en = !issue_done_ff;
            if (rd_en) begin
               if (addr_ff == LAST_IDX) begin
                  issue_done_in = 1'b1;
               end else begin
                  addr_in = addr_ff + IDX_W'(1);
               end
            end
            if (rd.stage) begin
               if (hit) begin
                  res_in.result_kind = KIND_HIT;
                  res_in.out_mac     = rd.mac;
                  res_in.out_ip      = '0;
                  state_in           = ST_HOLD;
               end else if (rd.last) begin
                  res_in.result_kind = KIND_MISS;
                  res_in.out_mac     = '0;
                  res_in.out_ip      = '0;
                  state_in           = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rd_addr = addr_ff;
   assign res     = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      res_ff        <= res_in;
      addr_ff       <= addr_in;
      issue_done_ff <= issue_done_in;
   end

endmodule
